FILE: sv/vn_pkg.sv
package vn_pkg;

   localparam int COMP_W   = 32;   // Q16.16 component and Q2.30 result width
   localparam int SQ_W     = 64;   // square of a component magnitude
   localparam int SUM_W    = 65;   // sum of up to four squares
   localparam int ACC_W    = 130;  // signed residual width in the root search
   localparam int Q_W      = 31;   // quotient bits, 0 .. 2^30
   localparam int LANES    = 4;
   localparam int DIM_W    = 3;
   localparam int R_SHIFT  = 62;

   localparam logic [DIM_W-1:0] DIM_RESET = 3'd3;
   localparam logic [DIM_W-1:0] DIM_THREE = 3'd3;
   localparam logic [DIM_W-1:0] DIM_FOUR  = 3'd4;

   // control that travels with each beat down a lane
   typedef struct packed {
      logic valid;
      logic neg;
      logic kill;
      logic zero;
   } lane_ctl_type;

endpackage

FILE: sv/vn_lane.sv
module vn_lane (
   input  logic                             clock,
   input  logic                             reset,
   input  vn_pkg::lane_ctl_type             ctl_in,
   input  logic [vn_pkg::SUM_W-1:0]         sum_in,
   input  logic [vn_pkg::SQ_W-1:0]          mag_sq_in,
   output vn_pkg::lane_ctl_type             ctl_out,
   output logic signed [vn_pkg::COMP_W-1:0] unit_out
);

   localparam int ACC_W = vn_pkg::ACC_W;
   localparam int Q_W   = vn_pkg::Q_W;

   vn_pkg::lane_ctl_type            ctl_ff [0:Q_W];
   logic signed [ACC_W-1:0]         d_ff   [0:Q_W];
   logic signed [ACC_W-1:0]         f_ff   [0:Q_W];
   logic [vn_pkg::SUM_W-1:0]        s_ff   [0:Q_W];
   logic [Q_W-1:0]                  q_ff   [0:Q_W];

   logic signed [ACC_W-1:0]         s_ext;
   logic signed [ACC_W-1:0]         r_ext;
   vn_pkg::lane_ctl_type            ctl_out_ff;
   logic signed [vn_pkg::COMP_W-1:0] unit_ff;
   logic [vn_pkg::COMP_W-1:0]       q_final_in;

   // start the search at q = 0: residual R - S, u*S = -S
   assign s_ext = {{(ACC_W-vn_pkg::SUM_W){1'b0}}, sum_in};
   assign r_ext = {{(ACC_W-vn_pkg::SQ_W-vn_pkg::R_SHIFT){1'b0}}, mag_sq_in,
                   {vn_pkg::R_SHIFT{1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0].valid <= 1'b0;
      end else begin
         ctl_ff[0].valid <= ctl_in.valid;
      end
      ctl_ff[0].neg  <= ctl_in.neg;
      ctl_ff[0].kill <= ctl_in.kill;
      ctl_ff[0].zero <= ctl_in.zero;
      d_ff[0] <= r_ext - s_ext;
      f_ff[0] <= -s_ext;
      s_ff[0] <= sum_in;
      q_ff[0] <= '0;
   end

   // one quotient bit per stage, most significant first
   for (genvar j = 0; j < Q_W; j++) begin : g_stage
      localparam int K = Q_W - 1 - j;
      logic signed [ACC_W-1:0] s_wide;
      logic signed [ACC_W-1:0] trial;
      logic                    pass;
      logic signed [ACC_W-1:0] d_in;
      logic signed [ACC_W-1:0] f_in;
      logic [Q_W-1:0]          q_in;

      assign s_wide = {{(ACC_W-vn_pkg::SUM_W){1'b0}}, s_ff[j]};
      assign trial  = d_ff[j] - (f_ff[j] <<< (K + 2)) - (s_wide <<< (2 * K + 2));
      assign pass   = ~trial[ACC_W-1];

      // take the bit when the residual stays non-negative
      always_comb begin
         d_in = d_ff[j];
         f_in = f_ff[j];
         q_in = q_ff[j];
         if (pass) begin
            d_in = trial;
            f_in = f_ff[j] + (s_wide <<< (K + 1));
            q_in = q_ff[j] | (Q_W'(1) << K);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[j+1].valid <= 1'b0;
         end else begin
            ctl_ff[j+1].valid <= ctl_ff[j].valid;
         end
         ctl_ff[j+1].neg  <= ctl_ff[j].neg;
         ctl_ff[j+1].kill <= ctl_ff[j].kill;
         ctl_ff[j+1].zero <= ctl_ff[j].zero;
         d_ff[j+1] <= d_in;
         f_ff[j+1] <= f_in;
         s_ff[j+1] <= s_ff[j];
         q_ff[j+1] <= q_in;
      end
   end

   // apply sign, drop unused or zero-length lanes
   always_comb begin
      q_final_in = {1'b0, q_ff[Q_W]};
      if (ctl_ff[Q_W].kill) begin
         q_final_in = '0;
      end else if (ctl_ff[Q_W].neg) begin
         q_final_in = -{1'b0, q_ff[Q_W]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_out_ff.valid <= 1'b0;
      end else begin
         ctl_out_ff.valid <= ctl_ff[Q_W].valid;
      end
      ctl_out_ff.neg  <= ctl_ff[Q_W].neg;
      ctl_out_ff.kill <= ctl_ff[Q_W].kill;
      ctl_out_ff.zero <= ctl_ff[Q_W].zero;
      unit_ff <= q_final_in;
   end

   assign ctl_out  = ctl_out_ff;
   assign unit_out = unit_ff;

endmodule

FILE: sv/vector_normalize.sv
// A taken start beat reaches the result strobe through the input register, the square register,
// the lane entry register, the root search stages and the output register.
// Throughput: one vector per cycle; busy stays low, a start is taken every cycle.
// The depth is set by the root search: one pipeline stage per quotient bit (31).
// Reset clears all valid bits and sets dimension to 3; results are never stalled.
module vector_normalize (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic signed [vn_pkg::COMP_W-1:0] req_comp_x,
   input  logic signed [vn_pkg::COMP_W-1:0] req_comp_y,
   input  logic signed [vn_pkg::COMP_W-1:0] req_comp_z,
   input  logic signed [vn_pkg::COMP_W-1:0] req_comp_w,
   output logic                             rsp_valid,
   output logic signed [vn_pkg::COMP_W-1:0] rsp_unit_x,
   output logic signed [vn_pkg::COMP_W-1:0] rsp_unit_y,
   output logic signed [vn_pkg::COMP_W-1:0] rsp_unit_z,
   output logic signed [vn_pkg::COMP_W-1:0] rsp_unit_w,
   output logic                             rsp_was_zero,
   input  logic                             csr_we,
   input  logic [vn_pkg::DIM_W-1:0]         csr_wdata
);

   localparam int LANES = vn_pkg::LANES;
   localparam int LAT   = 35;

   logic [vn_pkg::DIM_W-1:0]   dim_ff;
   logic                       in_valid_ff;
   logic [vn_pkg::COMP_W-1:0]  comp_ff [0:LANES-1];
   logic [LANES-1:0]           used_ff;
   logic                       sq_valid_ff;
   logic [vn_pkg::SQ_W-1:0]    sq_ff   [0:LANES-1];
   logic [LANES-1:0]           neg_ff;
   logic [LANES-1:0]           sq_used_ff;
   logic [vn_pkg::COMP_W-1:0]  mag     [0:LANES-1];
   logic [LANES-1:0]           used_in;
   logic [vn_pkg::SUM_W-1:0]   sum;
   logic                       zero;
   vn_pkg::lane_ctl_type       lane_ctl  [0:LANES-1];
   vn_pkg::lane_ctl_type       lane_done [0:LANES-1];
   logic signed [vn_pkg::COMP_W-1:0] lane_unit [0:LANES-1];

   function automatic logic [vn_pkg::SQ_W-1:0] SQ_W_mul(input logic [vn_pkg::COMP_W-1:0] m);
      logic [vn_pkg::SQ_W-1:0] m_ext;
      m_ext = {{(vn_pkg::SQ_W-vn_pkg::COMP_W){1'b0}}, m};
      return m_ext * m_ext;
   endfunction

   assign busy = 1'b0;

   // dimension register
   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= vn_pkg::DIM_RESET;
      end else if (csr_we) begin
         dim_ff <= csr_wdata;
      end
   end

   // components in use; below two acts as two, above four as four
   always_comb begin
      used_in    = 4'b0011;
      used_in[2] = (dim_ff >= vn_pkg::DIM_THREE);
      used_in[3] = (dim_ff >= vn_pkg::DIM_FOUR);
   end

   // capture the input beat
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start & ~busy;
      end
      comp_ff[0] <= req_comp_x;
      comp_ff[1] <= req_comp_y;
      comp_ff[2] <= req_comp_z;
      comp_ff[3] <= req_comp_w;
      used_ff    <= used_in;
   end

   // magnitudes and squares
   for (genvar i = 0; i < LANES; i++) begin : g_mag
      assign mag[i] = comp_ff[i][vn_pkg::COMP_W-1] ? -comp_ff[i] : comp_ff[i];

      always_ff @(posedge clock) begin
         sq_ff[i]  <= used_ff[i] ? SQ_W_mul(mag[i]) : '0;
         neg_ff[i] <= comp_ff[i][vn_pkg::COMP_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else begin
         sq_valid_ff <= in_valid_ff;
      end
      sq_used_ff <= used_ff;
   end

   // sum of squares at full width
   assign sum = {1'b0, sq_ff[0]} + {1'b0, sq_ff[1]} + {1'b0, sq_ff[2]} + {1'b0, sq_ff[3]};
   assign zero = (sum == '0);

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      always_comb begin
         lane_ctl[i].valid = sq_valid_ff;
         lane_ctl[i].neg   = neg_ff[i];
         lane_ctl[i].kill  = zero | ~sq_used_ff[i];
         lane_ctl[i].zero  = zero;
      end

      vn_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctl_in    (lane_ctl[i]),
         .sum_in    (sum),
         .mag_sq_in (sq_ff[i]),
         .ctl_out   (lane_done[i]),
         .unit_out  (lane_unit[i])
      );
   end

   assign rsp_valid    = lane_done[0].valid;
   assign rsp_was_zero = lane_done[0].zero;
   assign rsp_unit_x   = lane_unit[0];
   assign rsp_unit_y   = lane_unit[1];
   assign rsp_unit_z   = lane_unit[2];
   assign rsp_unit_w   = lane_unit[3];

   // every result comes from a start taken a fixed time earlier
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start & ~busy, LAT))
      else $error("result without matching start");

   // zero-length vector gives all-zero components
   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_was_zero) |->
         (rsp_unit_x == 0 && rsp_unit_y == 0 && rsp_unit_z == 0 && rsp_unit_w == 0))
      else $error("zero vector gave nonzero result");

   // x and w results never exceed unit length
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_unit_x <= 32'sh4000_0000 && rsp_unit_x >= -32'sh4000_0000 &&
                     rsp_unit_w <= 32'sh4000_0000 && rsp_unit_w >= -32'sh4000_0000))
      else $error("result above one");

   // lanes 0 and 3 stay in step
   a_lockstep: assert property (@(posedge clock) disable iff (reset)
      lane_done[0].valid == lane_done[3].valid)
      else $error("lanes out of step");

endmodule

FILE: tb/sv/vector_normalize_tb.sv
`timescale 1ns / 100ps

class unit_scoreboard;
   typedef struct {
      logic signed [31:0] ux, uy, uz, uw;
      logic               zero;
   } unit_result_type;

   unit_result_type pending[$];
   logic [2:0]   dim_reg;
   int           mismatches;

   function new();
      dim_reg = vn_pkg::DIM_RESET;
      mismatches = 0;
   endfunction

   // largest q in 0 .. 2^30 with (2q-1)^2 * sum <= 2^62 * mag^2
   function logic [30:0] unit_ratio(logic [64:0] sum, logic [32:0] mag);
      logic [159:0] rhs;
      logic [159:0] lhs;
      logic [31:0]  lo, hi, mid, odd;
      rhs = ({127'd0, mag} * {127'd0, mag}) << 62;
      lo = 0;
      hi = 32'h4000_0000;
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         odd = 2 * mid - 1;
         lhs = {95'd0, sum} * {128'd0, odd} * {128'd0, odd};
         if (lhs <= rhs) lo = mid;
         else hi = mid - 1;
      end
      return lo[30:0];
   endfunction

   // note an accepted vector and work out its normalized form
   function void note_vector(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                             logic [31:0] cw);
      logic [31:0]  comp [4];
      logic [32:0]  mag [4];
      logic [31:0]  q [4];
      logic [64:0]  sum;
      int           n;
      unit_result_type r;
      comp[0] = cx; comp[1] = cy; comp[2] = cz; comp[3] = cw;
      n = dim_reg < 2 ? 2 : (dim_reg > 4 ? 4 : dim_reg);
      sum = 0;
      for (int i = 0; i < 4; i++) begin
         mag[i] = comp[i][31] ? 33'h1_0000_0000 - {1'b0, comp[i]} : {1'b0, comp[i]};
         if (i >= n) mag[i] = 0;
         sum = sum + {32'd0, mag[i]} * {32'd0, mag[i]};
      end
      for (int i = 0; i < 4; i++) begin
         q[i] = 0;
         if (sum != 0 && i < n) begin
            q[i] = {1'b0, unit_ratio(sum, mag[i])};
            if (comp[i][31]) q[i] = -q[i];
         end
      end
      r.ux = q[0]; r.uy = q[1]; r.uz = q[2]; r.uw = q[3];
      r.zero = (sum == 0);
      pending.push_back(r);
   endfunction

   function void report(string what, logic [31:0] exp_v, logic [31:0] act_v);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch %s: expected %h actual %h", what, exp_v, act_v);
   endfunction

   // compare one result beat against the oldest expectation
   function void check_unit(logic [31:0] ux, logic [31:0] uy, logic [31:0] uz,
                            logic [31:0] uw, logic zero);
      unit_result_type e;
      if (pending.size() == 0) begin
         report("unexpected result", 0, ux);
         return;
      end
      e = pending.pop_front();
      if (ux !== e.ux) report("unit_x", e.ux, ux);
      if (uy !== e.uy) report("unit_y", e.uy, uy);
      if (uz !== e.uz) report("unit_z", e.uz, uz);
      if (uw !== e.uw) report("unit_w", e.uw, uw);
      if (zero !== e.zero) report("was_zero", e.zero, zero);
   endfunction
endclass

module vector_normalize_tb;

   logic                             clock = 0;
   logic                             reset = 1;
   logic                             start = 0;
   logic                             busy;
   logic signed [vn_pkg::COMP_W-1:0] req_comp_x = 0, req_comp_y = 0;
   logic signed [vn_pkg::COMP_W-1:0] req_comp_z = 0, req_comp_w = 0;
   logic                             rsp_valid;
   logic signed [vn_pkg::COMP_W-1:0] rsp_unit_x, rsp_unit_y, rsp_unit_z, rsp_unit_w;
   logic                             rsp_was_zero;
   logic                             csr_we = 0;
   logic [vn_pkg::DIM_W-1:0]         csr_wdata = 0;

   unit_scoreboard board = new();
   int                       idle_pct;

   vector_normalize dut (.*);

   always #6 clock = ~clock;

   // note accepted beats and check result beats
   always @(posedge clock) begin
      if (!reset && start && !busy)
         board.note_vector(req_comp_x, req_comp_y, req_comp_z, req_comp_w);
      if (!reset && rsp_valid)
         board.check_unit(rsp_unit_x, rsp_unit_y, rsp_unit_z, rsp_unit_w, rsp_was_zero);
   end

   task automatic send_vector(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                              logic [31:0] cw);
      start <= 1;
      req_comp_x <= cx; req_comp_y <= cy; req_comp_z <= cz; req_comp_w <= cw;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      // idle each following cycle at the phase's rate
      while ($urandom_range(99) < idle_pct) begin
         start <= 0;
         @(posedge clock);
      end
   endtask

   // drain the pipe, then write the dimension
   task automatic write_dim(logic [2:0] d);
      start <= 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_we <= 1;
      csr_wdata <= d;
      board.dim_reg = d;
      @(posedge clock);
      csr_we <= 0;
   endtask

   function automatic logic [31:0] rand_comp();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 0;
         3, 4: return $urandom_range(0, 255) - 128;
         5: return {$urandom} >> $urandom_range(31);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [2:0] dims [8] = '{3'd2, 3'd4, 3'd0, 3'd5, 3'd3, 3'd1, 3'd7, 3'd6};
      repeat (3) @(posedge clock);
      reset <= 0;
      idle_pct = 0;

      // extremes, single axes, zero vectors at the reset dimension, then at four and two
      send_vector(0, 0, 0, 0);
      send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_vector(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_vector(32'h0001_0000, 0, 0, 0);
      send_vector(0, 32'hffff_0000, 0, 0);
      send_vector(0, 0, 1, 32'h1234_5678);
      send_vector(0, 0, 0, 32'h7fff_ffff);
      send_vector(1, 32'hffff_ffff, 1, 0);
      send_vector(32'h8000_0000, 1, 0, 0);
      send_vector(32'h0003_0000, 32'h0004_0000, 0, 32'h8000_0000);
      write_dim(3'd4);
      send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_vector(0, 0, 0, 32'h8000_0000);
      send_vector(1, 1, 1, 1);
      send_vector(0, 0, 0, 0);
      write_dim(3'd2);
      send_vector(0, 0, 32'h7fff_ffff, 32'h7fff_ffff);
      send_vector(32'h8000_0000, 32'h7fff_ffff, 5, 5);
      send_vector(32'hffff_ffff, 0, 0, 0);

      // random phases across dimensions and idle rates
      for (int p = 0; p < 8; p++) begin
         write_dim(dims[p]);
         idle_pct = (p % 4 == 1) ? 85 : ((p % 4 == 3) ? 31 : 0);
         repeat (80) send_vector(rand_comp(), rand_comp(), rand_comp(), rand_comp());
      end

      start <= 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // drop out if the block hangs
   initial begin
      #5ms;
      $display("end of test: mismatches");
      $finish;
   end
endmodule

FILE: filelist.f
sv/vn_pkg.sv
sv/vn_lane.sv
sv/vector_normalize.sv
tb/sv/vector_normalize_tb.sv
